@@ rtl/core/vrd_pkg.sv @@
// Shared constants and types for the voxel ray traversal block.
package vrd_pkg;

  localparam int GRID_BITS = 5;
  localparam int FRAC_BITS = 16;

  localparam int ORG_W    = 32;
  localparam int DIR_W    = 16;
  localparam int LIMIT_W  = 12;
  localparam int VOX_W    = 5;
  localparam int TYPE_W   = 8;
  localparam int OCELL_W  = 16;
  localparam int FACE_W   = 2;

  localparam int ADDR_W   = 3 * GRID_BITS;
  localparam int DEPTH    = 1 << ADDR_W;

  localparam int SUM_W    = 32;
  localparam int LEN_W    = 16;
  localparam int DELTA_W  = 32;
  localparam int SIDE0_W  = DELTA_W + 1;
  localparam int SIDE_W   = SIDE0_W + LIMIT_W + 1;
  localparam int CELL_W   = ORG_W - FRAC_BITS + LIMIT_W + 1;
  localparam int MA_W     = (FRAC_BITS + 1 > DIR_W) ? FRAC_BITS + 1 : DIR_W;
  localparam int PROD_W   = MA_W + DELTA_W;

  localparam int REM_W    = 20;
  localparam int ITER_W   = 5;
  localparam int SQRT_ITER = 16;
  localparam int DIV_ITER  = 32;

  localparam logic [MA_W-1:0] ONE_FX = MA_W'(1) << FRAC_BITS;

  localparam logic [FACE_W-1:0] STEP_POS  = 2'b01;
  localparam logic [FACE_W-1:0] STEP_NEG  = 2'b11;
  localparam logic [FACE_W-1:0] STEP_NONE = 2'b00;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } dsq_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dsq_sts_t;

  function automatic logic [DIR_W-1:0] mag_f(input logic signed [DIR_W-1:0] d);
    mag_f = d[DIR_W-1] ? (~d + 1'b1) : d;
  endfunction

endpackage

@@ rtl/core/vrd_ram.sv @@
// Generic single-port RAM with registered read.
module vrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/vrd_dsq.sv @@
// Shared iterative unit: restoring square root and division, one digit per cycle.
module vrd_dsq
  import vrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dsq_ctl_t           ctl,
  input  logic [SUM_W-1:0]   opa,
  input  logic [DIR_W-1:0]   opb,
  output dsq_sts_t           sts,
  output logic [DELTA_W-1:0] res
);

  logic [SUM_W-1:0]   acc_r;
  logic [REM_W-1:0]   rem_r;
  logic [DELTA_W-1:0] res_r;
  logic [DIR_W-1:0]   div_r;
  logic [ITER_W-1:0]  cnt_r;
  logic               busy_r, done_r, sqrt_r;

  logic [REM_W-1:0] rem_sh, trial, diff;
  logic             ge, last;

  always_comb begin
    if (sqrt_r) begin
      rem_sh = {rem_r[REM_W-3:0], acc_r[SUM_W-1 -: 2]};
      trial  = {{(REM_W-LEN_W-2){1'b0}}, res_r[LEN_W-1:0], 2'b01};
      last   = (cnt_r == ITER_W'(SQRT_ITER - 1));
    end else begin
      rem_sh = {rem_r[REM_W-2:0], acc_r[SUM_W-1]};
      trial  = {{(REM_W-DIR_W){1'b0}}, div_r};
      last   = (cnt_r == ITER_W'(DIV_ITER - 1));
    end
    ge   = (rem_sh >= trial);
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r  <= opa;
      div_r  <= opb;
      rem_r  <= '0;
      res_r  <= '0;
      cnt_r  <= '0;
      sqrt_r <= ctl.sqrt_mode;
    end else if (busy_r) begin
      acc_r <= sqrt_r ? (acc_r << 2) : (acc_r << 1);
      rem_r <= ge ? diff : rem_sh;
      res_r <= {res_r[DELTA_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = res_r;

endmodule

@@ rtl/core/voxel_ray_dda_traversal.sv @@
// Voxel ray traversal: sequencer, walk datapath and voxel store.
// A write transaction is stored on acceptance; its result is offered the next cycle.
// A cast first computes the squares, the square root, three divisions on
// the shared digit unit and the side products, then reads and checks one cell at a time.
// One transaction at a time; the next is taken once the result has left.
// After reset a clearing pass writes all 32768 voxels, with in_stall high.
module voxel_ray_dda_traversal
  import vrd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic signed [ORG_W-1:0]    in_origin_x,
  input  logic signed [ORG_W-1:0]    in_origin_y,
  input  logic signed [ORG_W-1:0]    in_origin_z,
  input  logic signed [DIR_W-1:0]    in_dir_x,
  input  logic signed [DIR_W-1:0]    in_dir_y,
  input  logic signed [DIR_W-1:0]    in_dir_z,
  input  logic [LIMIT_W-1:0]         in_step_limit,
  input  logic [VOX_W-1:0]           in_voxel_x,
  input  logic [VOX_W-1:0]           in_voxel_y,
  input  logic [VOX_W-1:0]           in_voxel_z,
  input  logic [TYPE_W-1:0]          in_voxel_type,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [TYPE_W-1:0]          out_block_type,
  output logic signed [OCELL_W-1:0]  out_cell_x,
  output logic signed [OCELL_W-1:0]  out_cell_y,
  output logic signed [OCELL_W-1:0]  out_cell_z,
  output logic signed [FACE_W-1:0]   out_face_x,
  output logic signed [FACE_W-1:0]   out_face_y,
  output logic signed [FACE_W-1:0]   out_face_z,
  output logic                       out_hit
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SQ    = 9'b000000100,
    S_SQRT  = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_SIDE  = 9'b000100000,
    S_RD    = 9'b001000000,
    S_CHK   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r;

  logic [ADDR_W-1:0]        clr_r;
  logic [1:0]               ax_r;
  logic [1:0]               pax;
  logic [1:0]               axc;
  logic start_r;

  logic signed [DIR_W-1:0]  dir_r   [3];
  logic [FRAC_BITS-1:0]     frac_r  [3];
  logic [LIMIT_W-1:0]       limit_r, cnt_r;
  logic [SUM_W-1:0]         sum_r;
  logic [PROD_W-1:0]        prod_r;
  logic [LEN_W-1:0]         len_r;
  logic [DELTA_W-1:0]       delta_r [3];
  logic [SIDE_W-1:0]        side_r  [3];
  logic [2:0]               inf_r;
  logic signed [CELL_W-1:0] cell_r  [3];
  logic [FACE_W-1:0]        face_r  [3];
  logic [FACE_W-1:0]        step    [3];
  logic                     ingrid_r;

  logic [TYPE_W-1:0] o_type_r;
  logic [OCELL_W-1:0] o_cell_r [3];
  logic [FACE_W-1:0]  o_face_r [3];

  logic in_acc;
  logic [MA_W-1:0]    mul_a;
  logic [DELTA_W-1:0] mul_b;
  logic [DIR_W-1:0]   mag;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [TYPE_W-1:0] ram_wdata, ram_rdata;
  logic [TYPE_W-1:0] typ;
  logic              ingrid;
  logic [1:0]        mv;
  logic              done_walk;

  dsq_ctl_t           dctl;
  dsq_sts_t           dsts;
  logic [SUM_W-1:0]   dopa;
  logic [DELTA_W-1:0] dres;

  function automatic logic lt_f(input logic ia, input logic ib,
                                input logic [SIDE_W-1:0] a, input logic [SIDE_W-1:0] b);
    lt_f = !ia && (ib || (a < b));
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);

  assign axc = (ax_r == 2'd3) ? 2'd2 : ax_r;
  assign pax = ax_r - 2'd1;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (dir_r[a] == '0)         step[a] = STEP_NONE;
      else if (dir_r[a][DIR_W-1]) step[a] = STEP_NEG;
      else                        step[a] = STEP_POS;
    end
  end

  // shared multiplier: squares of the direction, then side products
  always_comb begin
    mag = mag_f(dir_r[axc]);
    if (state_r == S_SIDE) begin
      mul_a = (step[axc] == STEP_POS) ? (ONE_FX - MA_W'(frac_r[axc])) : MA_W'(frac_r[axc]);
      mul_b = delta_r[axc];
    end else begin
      mul_a = MA_W'(mag);
      mul_b = DELTA_W'(mag);
    end
  end

  assign dctl.start     = start_r;
  assign dctl.sqrt_mode = (state_r == S_SQRT);
  assign dopa = (state_r == S_SQRT) ? sum_r : {len_r, {(SUM_W-LEN_W){1'b0}}};

  vrd_dsq u_dsq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dctl),
    .opa   (dopa),
    .opb   (mag),
    .sts   (dsts),
    .res   (dres)
  );

  always_comb begin
    ingrid = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (cell_r[a][CELL_W-1:GRID_BITS] != '0) ingrid = 1'b0;
    end
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = {cell_r[2][GRID_BITS-1:0], cell_r[1][GRID_BITS-1:0],
                 cell_r[0][GRID_BITS-1:0]};
    if (state_r == S_CLEAR) begin
      ram_we   = 1'b1;
      ram_addr = clr_r;
    end else if (in_acc && in_op == OP_WRITE) begin
      ram_we    = 1'b1;
      ram_wdata = in_voxel_type;
      ram_addr  = {GRID_BITS'(in_voxel_z), GRID_BITS'(in_voxel_y), GRID_BITS'(in_voxel_x)};
    end
  end

  vrd_ram #(.WIDTH(TYPE_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // axis choice: ties go to the later axis, z over y over x
  always_comb begin
    typ = ingrid_r ? ram_rdata : '0;
    done_walk = (typ != '0) || (cnt_r == limit_r - 1'b1);
    if (lt_f(inf_r[0], inf_r[1], side_r[0], side_r[1]))
      mv = lt_f(inf_r[0], inf_r[2], side_r[0], side_r[2]) ? 2'd0 : 2'd2;
    else
      mv = lt_f(inf_r[1], inf_r[2], side_r[1], side_r[2]) ? 2'd1 : 2'd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_op == OP_CAST && in_step_limit != '0) state_r <= S_SQ;
            else                                          state_r <= S_OUT;
          end
        end
        S_SQ: begin
          if (ax_r == 2'd3) begin
            state_r <= S_SQRT;
            start_r <= 1'b1;
          end
        end
        S_SQRT: begin
          if (dsts.done) begin
            state_r <= S_DIV;
            start_r <= 1'b1;
          end
        end
        S_DIV: begin
          if (dsts.done) begin
            if (ax_r == 2'd2) state_r <= S_SIDE;
            else              start_r <= 1'b1;
          end
        end
        S_SIDE: begin
          if (ax_r == 2'd3) state_r <= S_RD;
        end
        S_RD:  state_r <= S_CHK;
        S_CHK: state_r <= done_walk ? S_OUT : S_RD;
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    case (state_r)
      S_IDLE: begin
        ax_r     <= '0;
        sum_r    <= '0;
        cnt_r    <= '0;
        o_type_r <= '0;
        for (int a = 0; a < 3; a++) begin
          o_cell_r[a] <= '0;
          o_face_r[a] <= '0;
          face_r[a]   <= '0;
        end
        limit_r   <= in_step_limit;
        dir_r[0]  <= in_dir_x;
        dir_r[1]  <= in_dir_y;
        dir_r[2]  <= in_dir_z;
        frac_r[0] <= in_origin_x[FRAC_BITS-1:0];
        frac_r[1] <= in_origin_y[FRAC_BITS-1:0];
        frac_r[2] <= in_origin_z[FRAC_BITS-1:0];
        cell_r[0] <= CELL_W'(in_origin_x >>> FRAC_BITS);
        cell_r[1] <= CELL_W'(in_origin_y >>> FRAC_BITS);
        cell_r[2] <= CELL_W'(in_origin_z >>> FRAC_BITS);
      end
      S_SQ: begin
        if (ax_r != 2'd0) sum_r <= sum_r + prod_r[SUM_W-1:0];
        ax_r <= ax_r + 1'b1;
      end
      S_SQRT: begin
        if (dsts.done) begin
          len_r <= dres[LEN_W-1:0];
          ax_r  <= '0;
        end
      end
      S_DIV: begin
        if (dsts.done) begin
          delta_r[ax_r[1:0] == 2'd3 ? 2'd2 : ax_r] <= dres;
          ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 1'b1;
        end
      end
      S_SIDE: begin
        if (ax_r != 2'd0) begin
          side_r[pax] <= SIDE_W'(prod_r[FRAC_BITS +: SIDE0_W]);
          inf_r[pax]  <= (dir_r[pax] == '0);
        end
        ax_r <= ax_r + 1'b1;
      end
      S_RD: ingrid_r <= ingrid;
      S_CHK: begin
        if (done_walk) begin
          o_type_r <= typ;
          for (int a = 0; a < 3; a++) begin
            o_cell_r[a] <= cell_r[a][OCELL_W-1:0];
            o_face_r[a] <= face_r[a];
          end
        end else begin
          cnt_r <= cnt_r + 1'b1;
          if (!inf_r[mv]) side_r[mv] <= side_r[mv] + SIDE_W'(delta_r[mv]);
          cell_r[mv] <= cell_r[mv] + {{(CELL_W-FACE_W){step[mv][FACE_W-1]}}, step[mv]};
          for (int a = 0; a < 3; a++) begin
            face_r[a] <= (a == int'(mv)) ? -step[mv] : '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_block_type = o_type_r;
  assign out_cell_x = o_cell_r[0];
  assign out_cell_y = o_cell_r[1];
  assign out_cell_z = o_cell_r[2];
  assign out_face_x = o_face_r[0];
  assign out_face_y = o_face_r[1];
  assign out_face_z = o_face_r[2];
  assign out_hit    = (o_type_r != '0);

endmodule

@@ rtl/core/vrd_chk.sv @@
// Port-level checker for the voxel ray traversal block, with its bind.
module vrd_chk
  import vrd_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic [TYPE_W-1:0]         out_block_type,
  input logic signed [FACE_W-1:0]  out_face_x,
  input logic signed [FACE_W-1:0]  out_face_y,
  input logic signed [FACE_W-1:0]  out_face_z,
  input logic                      out_hit
);

  a_hit_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_block_type != '0)
    else $error("hit with empty block type");

  a_miss_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_block_type == '0)
    else $error("miss with nonzero block type");

  a_one_txn: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({out_face_x != 2'b00, out_face_y != 2'b00,
                               out_face_z != 2'b00}) <= 1)
                  && out_face_x != 2'b10 && out_face_y != 2'b10 && out_face_z != 2'b10)
    else $error("bad entry face normal");

endmodule

bind voxel_ray_dda_traversal vrd_chk u_vrd_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_block_type (out_block_type),
  .out_face_x     (out_face_x),
  .out_face_y     (out_face_y),
  .out_face_z     (out_face_z),
  .out_hit        (out_hit)
);
